// ===== hdl/amg_pkg.sv =====
// Shared types, command codes and the microcode table of the adjacency matrix graph store.
// Depends on nothing; the top level and amg_seq import it.
`default_nettype none

package amg_pkg;

  typedef enum logic [1:0] {
    CMD_INS_NODE = 2'd0,
    CMD_DEL_NODE = 2'd1,
    CMD_INS_EDGE = 2'd2,
    CMD_DEL_EDGE = 2'd3
  } cmd_t;

  // Jump conditions of one microcode step.
  typedef enum logic [3:0] {
    JMP_NEXT     = 4'd0,
    JMP_GOTO     = 4'd1,
    JMP_WAIT_IN  = 4'd2,
    JMP_LOOP     = 4'd3,
    JMP_DISPATCH = 4'd4,
    JMP_NO_FREE  = 4'd5,
    JMP_NO_A     = 4'd6,
    JMP_NO_AB    = 4'd7,
    JMP_BIT_SET  = 4'd8,
    JMP_BIT_CLR  = 4'd9,
    JMP_WAIT_OUT = 4'd10
  } jump_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t S_IDLE     = 5'd0;
  localparam pc_t S_SCAN     = 5'd1;
  localparam pc_t S_DRAIN    = 5'd2;
  localparam pc_t S_IN_CHK   = 5'd3;
  localparam pc_t S_IN_ADD   = 5'd4;
  localparam pc_t S_DN_CHK   = 5'd5;
  localparam pc_t S_DN_RD    = 5'd6;
  localparam pc_t S_DN_LATCH = 5'd7;
  localparam pc_t S_DN_SWEEP = 5'd8;
  localparam pc_t S_DN_DRAIN = 5'd9;
  localparam pc_t S_DN_DONE  = 5'd10;
  localparam pc_t S_IE_CHK   = 5'd11;
  localparam pc_t S_IE_RD    = 5'd12;
  localparam pc_t S_IE_LATCH = 5'd13;
  localparam pc_t S_IE_TEST  = 5'd14;
  localparam pc_t S_IE_SET   = 5'd15;
  localparam pc_t S_DE_CHK   = 5'd16;
  localparam pc_t S_DE_RD    = 5'd17;
  localparam pc_t S_DE_LATCH = 5'd18;
  localparam pc_t S_DE_TEST  = 5'd19;
  localparam pc_t S_DE_CLR   = 5'd20;
  localparam pc_t S_RESULT   = 5'd21;

  typedef struct packed {
    logic  accept;
    logic  cnt_clr;
    logic  scan_rd;
    logic  adj_rd_a;
    logic  row_latch;
    logic  sweep_rd;
    logic  node_add;
    logic  node_del;
    logic  edge_set;
    logic  edge_clr;
    logic  set_ok;
    logic  out_load;
    jump_t jump;
    pc_t   target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic cnt_last;
    logic free_found;
    logic found_a;
    logic found_b;
    logic edge_bit;
    cmd_t cmd;
  } stat_t;

  function automatic pc_t dispatch(cmd_t cmd);
    pc_t p;
    case (cmd)
      CMD_INS_NODE: p = S_IN_CHK;
      CMD_DEL_NODE: p = S_DN_CHK;
      CMD_INS_EDGE: p = S_IE_CHK;
      CMD_DEL_EDGE: p = S_DE_CHK;
      default:      p = S_IDLE;
    endcase
    return p;
  endfunction

  function automatic ctl_t ucode(pc_t pc);
    ctl_t c;
    c        = '0;
    c.jump   = JMP_NEXT;
    c.target = S_RESULT;
    case (pc)
      S_IDLE: begin
        c.accept = 1'b1;
        c.cnt_clr = 1'b1;
        c.jump = JMP_WAIT_IN;
      end
      S_SCAN: begin
        c.scan_rd = 1'b1;
        c.jump = JMP_LOOP;
        c.target = S_SCAN;
      end
      S_DRAIN:    c.jump = JMP_DISPATCH;
      S_IN_CHK:   c.jump = JMP_NO_FREE;
      S_IN_ADD: begin
        c.node_add = 1'b1;
        c.jump = JMP_GOTO;
      end
      S_DN_CHK: begin
        c.cnt_clr = 1'b1;
        c.jump = JMP_NO_A;
      end
      S_DN_RD:    c.adj_rd_a = 1'b1;
      S_DN_LATCH: begin
        c.row_latch = 1'b1;
        c.sweep_rd = 1'b1;
      end
      S_DN_SWEEP: begin
        c.sweep_rd = 1'b1;
        c.jump = JMP_LOOP;
        c.target = S_DN_SWEEP;
      end
      S_DN_DRAIN: c.jump = JMP_NEXT;
      S_DN_DONE: begin
        c.node_del = 1'b1;
        c.jump = JMP_GOTO;
      end
      S_IE_CHK:   c.jump = JMP_NO_AB;
      S_IE_RD:    c.adj_rd_a = 1'b1;
      S_IE_LATCH: c.row_latch = 1'b1;
      S_IE_TEST:  c.jump = JMP_BIT_SET;
      S_IE_SET: begin
        c.edge_set = 1'b1;
        c.jump = JMP_GOTO;
      end
      S_DE_CHK:   c.jump = JMP_NO_AB;
      S_DE_RD: begin
        c.adj_rd_a = 1'b1;
        c.set_ok = 1'b1;
      end
      S_DE_LATCH: c.row_latch = 1'b1;
      S_DE_TEST:  c.jump = JMP_BIT_CLR;
      S_DE_CLR: begin
        c.edge_clr = 1'b1;
        c.jump = JMP_GOTO;
      end
      S_RESULT: begin
        c.out_load = 1'b1;
        c.jump = JMP_WAIT_OUT;
        c.target = S_IDLE;
      end
      default: begin
        c.jump = JMP_GOTO;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/adjacency_matrix_graph_store.sv =====
// Top level of the directed graph store: node slot table, adjacency row memory and datapath.
// Depends on amg_pkg, amg_ram and amg_seq.
//
//   channel | ports                                           | dir | handshake
//   --------+-------------------------------------------------+-----+---------------------
//   input   | in_cmd, in_key_a, in_key_b                      | in  | in_valid / in_stall
//   result  | out_ok, out_node_count, out_edge_count,         | out | out_valid / out_stall
//           | out_graph_empty                                 |     |
//
// One item at a time. Refusals finish sooner than a full command, and the next item is
// taken in the cycle after the result register loads at the earliest.
// The key scan reads every slot; delete node adds a sweep over all rows that clears its column.
// Reset is synchronous and needs no clearing pass: slots and rows carry valid flip-flops.
// The sequencer stays at its last step while out_stall holds the waiting result beat.
`default_nettype none

module adjacency_matrix_graph_store
  import amg_pkg::*;
#(
  parameter int MAX_NODES = 32,
  parameter int KEY_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_cmd,
  input  wire logic signed [15:0] in_key_a,
  input  wire logic signed [15:0] in_key_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_ok,
  output logic             [5:0]  out_node_count,
  output logic             [10:0] out_edge_count,
  output logic                    out_graph_empty
);

  localparam int SW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int EW = $clog2(MAX_NODES * MAX_NODES + 1);
  localparam int RW = $clog2(2 * MAX_NODES);
  localparam logic [SW-1:0] LAST = SW'(MAX_NODES - 1);

  ctl_t  ctl;
  stat_t st;

  logic in_fire;
  logic out_free;
  logic out_load_fire;

  logic signed [31:0] ka_ext;
  logic signed [31:0] kb_ext;

  cmd_t                 cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0] ka_r, ka_nxt;
  logic [KEY_WIDTH-1:0] kb_r, kb_nxt;
  logic [SW-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]        pidx_r, pidx_nxt;
  logic                 pend_scan_r, pend_scan_nxt;
  logic                 pend_sweep_r, pend_sweep_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [SW-1:0]        free_idx_r, free_idx_nxt;
  logic                 found_a_r, found_a_nxt;
  logic [SW-1:0]        slot_a_r, slot_a_nxt;
  logic                 found_b_r, found_b_nxt;
  logic [SW-1:0]        slot_b_r, slot_b_nxt;
  logic [MAX_NODES-1:0] row_s_r, row_s_nxt;
  logic [RW-1:0]        removed_r, removed_nxt;
  logic                 adj_rv_q_r, adj_rv_q_nxt;
  logic [MAX_NODES-1:0] slot_valid_r, slot_valid_nxt;
  logic [MAX_NODES-1:0] row_valid_r, row_valid_nxt;
  logic [NW-1:0]        nodes_held_r, nodes_held_nxt;
  logic [EW-1:0]        edges_held_r, edges_held_nxt;
  logic                 ok_r, ok_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [5:0]           out_node_count_r;
  logic [10:0]          out_edge_count_r;
  logic                 out_graph_empty_r;

  logic                 key_we;
  logic [KEY_WIDTH-1:0] key_rdata;
  logic                 adj_we;
  logic [SW-1:0]        adj_waddr;
  logic [MAX_NODES-1:0] adj_wdata;
  logic                 adj_re;
  logic [SW-1:0]        adj_raddr;
  logic [MAX_NODES-1:0] adj_rdata;
  logic [MAX_NODES-1:0] adj_row;
  logic [MAX_NODES-1:0] sel_a;
  logic [MAX_NODES-1:0] sel_b;
  logic                 slot_hit;

  amg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  amg_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_NODES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_idx_r),
    .wdata (ka_r),
    .re    (ctl.scan_rd),
    .raddr (cnt_r),
    .rdata (key_rdata)
  );

  amg_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  assign in_fire       = ctl.accept && in_valid;
  // No input beat is taken while reset is held.
  assign in_stall      = !ctl.accept || !rst_n;
  assign out_free      = !out_valid_r || !out_stall;
  assign out_load_fire = ctl.out_load && out_free;

  assign st.in_valid   = in_valid;
  assign st.out_free   = out_free;
  assign st.cnt_last   = (cnt_r == LAST);
  assign st.free_found = free_found_r;
  assign st.found_a    = found_a_r;
  assign st.found_b    = found_b_r;
  assign st.edge_bit   = row_s_r[slot_b_r];
  assign st.cmd        = cmd_r;

  // Keys are sign-extended from the 16-bit field and kept in their low KEY_WIDTH bits.
  assign ka_ext = 32'(in_key_a);
  assign kb_ext = 32'(in_key_b);

  // A row that was never written reads as all zero.
  assign adj_row  = adj_rv_q_r ? adj_rdata : '0;
  assign sel_a    = MAX_NODES'(1) << slot_a_r;
  assign sel_b    = MAX_NODES'(1) << slot_b_r;
  assign slot_hit = (pidx_r == slot_a_r);

  assign key_we    = ctl.node_add;
  assign adj_re    = ctl.adj_rd_a || ctl.sweep_rd;
  assign adj_raddr = ctl.sweep_rd ? cnt_r : slot_a_r;

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = slot_a_r;
    adj_wdata = row_s_r;
    if (pend_sweep_r) begin
      adj_we    = 1'b1;
      adj_waddr = pidx_r;
      adj_wdata = slot_hit ? '0 : (adj_row & ~sel_a);
    end else if (ctl.edge_set) begin
      adj_we    = 1'b1;
      adj_wdata = row_s_r | sel_b;
    end else if (ctl.edge_clr) begin
      adj_we    = 1'b1;
      adj_wdata = row_s_r & ~sel_b;
    end
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    ka_nxt         = ka_r;
    kb_nxt         = kb_r;
    cnt_nxt        = cnt_r;
    pidx_nxt       = pidx_r;
    pend_scan_nxt  = ctl.scan_rd;
    pend_sweep_nxt = ctl.sweep_rd;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    found_a_nxt    = found_a_r;
    slot_a_nxt     = slot_a_r;
    found_b_nxt    = found_b_r;
    slot_b_nxt     = slot_b_r;
    row_s_nxt      = row_s_r;
    removed_nxt    = removed_r;
    adj_rv_q_nxt   = adj_rv_q_r;
    slot_valid_nxt = slot_valid_r;
    row_valid_nxt  = row_valid_r;
    nodes_held_nxt = nodes_held_r;
    edges_held_nxt = edges_held_r;
    ok_nxt         = ok_r;

    if (in_fire) begin
      cmd_nxt        = cmd_t'(in_cmd);
      ka_nxt         = ka_ext[KEY_WIDTH-1:0];
      kb_nxt         = kb_ext[KEY_WIDTH-1:0];
      free_found_nxt = 1'b0;
      found_a_nxt    = 1'b0;
      found_b_nxt    = 1'b0;
      ok_nxt         = 1'b0;
    end

    if (ctl.cnt_clr) begin
      cnt_nxt     = '0;
      removed_nxt = '0;
    end else if (ctl.scan_rd || ctl.sweep_rd) begin
      cnt_nxt  = SW'(cnt_r + 1'b1);
      pidx_nxt = cnt_r;
    end

    if (adj_re) begin
      adj_rv_q_nxt = row_valid_r[adj_raddr];
    end

    // Key compare in the cycle after the read is issued; free slots are skipped, not a stop.
    if (pend_scan_r) begin
      if (!slot_valid_r[pidx_r]) begin
        if (!free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = pidx_r;
        end
      end else begin
        if (!found_a_r && key_rdata == ka_r) begin
          found_a_nxt = 1'b1;
          slot_a_nxt  = pidx_r;
        end
        if (!found_b_r && key_rdata == kb_r) begin
          found_b_nxt = 1'b1;
          slot_b_nxt  = pidx_r;
        end
      end
    end

    // Row s itself counts its self-loop bit once; any other row adds its own column bit too.
    if (pend_sweep_r) begin
      if (slot_hit) begin
        removed_nxt = RW'(removed_r + RW'(row_s_r[pidx_r]));
      end else begin
        removed_nxt = RW'(removed_r + RW'(row_s_r[pidx_r]) + RW'(adj_row[slot_a_r]));
      end
    end

    if (ctl.row_latch) begin
      row_s_nxt = adj_row;
    end

    if (adj_we) begin
      row_valid_nxt[adj_waddr] = 1'b1;
    end

    if (ctl.set_ok) begin
      ok_nxt = 1'b1;
    end

    if (ctl.node_add) begin
      slot_valid_nxt[free_idx_r] = 1'b1;
      nodes_held_nxt = NW'(nodes_held_r + 1'b1);
      ok_nxt = 1'b1;
    end

    if (ctl.node_del) begin
      slot_valid_nxt[slot_a_r] = 1'b0;
      nodes_held_nxt = NW'(nodes_held_r - 1'b1);
      edges_held_nxt = EW'(edges_held_r - EW'(removed_r));
      ok_nxt = 1'b1;
    end

    if (ctl.edge_set) begin
      edges_held_nxt = EW'(edges_held_r + 1'b1);
      ok_nxt = 1'b1;
    end

    if (ctl.edge_clr) begin
      edges_held_nxt = EW'(edges_held_r - 1'b1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_scan_r  <= 1'b0;
      pend_sweep_r <= 1'b0;
      free_found_r <= 1'b0;
      found_a_r    <= 1'b0;
      found_b_r    <= 1'b0;
      cnt_r        <= '0;
      removed_r    <= '0;
      adj_rv_q_r   <= 1'b0;
      slot_valid_r <= '0;
      row_valid_r  <= '0;
      nodes_held_r <= '0;
      edges_held_r <= '0;
      ok_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_scan_r  <= pend_scan_nxt;
      pend_sweep_r <= pend_sweep_nxt;
      free_found_r <= free_found_nxt;
      found_a_r    <= found_a_nxt;
      found_b_r    <= found_b_nxt;
      cnt_r        <= cnt_nxt;
      removed_r    <= removed_nxt;
      adj_rv_q_r   <= adj_rv_q_nxt;
      slot_valid_r <= slot_valid_nxt;
      row_valid_r  <= row_valid_nxt;
      nodes_held_r <= nodes_held_nxt;
      edges_held_r <= edges_held_nxt;
      ok_r         <= ok_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ka_r       <= ka_nxt;
    kb_r       <= kb_nxt;
    pidx_r     <= pidx_nxt;
    free_idx_r <= free_idx_nxt;
    slot_a_r   <= slot_a_nxt;
    slot_b_r   <= slot_b_nxt;
    row_s_r    <= row_s_nxt;
    if (out_load_fire) begin
      out_ok_r          <= ok_r;
      out_node_count_r  <= 6'(nodes_held_r);
      out_edge_count_r  <= 11'(edges_held_r);
      out_graph_empty_r <= (nodes_held_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_node_count  = out_node_count_r;
  assign out_edge_count  = out_edge_count_r;
  assign out_graph_empty = out_graph_empty_r;

`ifndef NO_ASSERTIONS
  // The running node count always agrees with the slot valid bits.
  a_node_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == nodes_held_r)
    else $error("node count differs from the number of valid slots");

  // With no node stored, no edge can remain.
  a_no_orphan_edges: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_held_r == '0) |-> (edges_held_r == '0))
    else $error("edges remain in an empty graph");

  // The key scan and the row sweep never overlap.
  a_scan_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_scan_r && pend_sweep_r))
    else $error("key scan and row sweep active together");
`endif

endmodule

`default_nettype wire

// ===== hdl/amg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stand-alone; used for the slot key store and the adjacency matrix rows.
`default_nettype none

module amg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/amg_seq.sv =====
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on amg_pkg for the control word, status bundle and program table.
`default_nettype none

module amg_seq
  import amg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire stat_t st,
  output ctl_t       ctl
);

  pc_t pc_r;
  pc_t pc_nxt;

  assign ctl = ucode(pc_r);

  always_comb begin
    pc_nxt = pc_t'(pc_r + 1'b1);
    case (ctl.jump)
      JMP_NEXT:     pc_nxt = pc_t'(pc_r + 1'b1);
      JMP_GOTO:     pc_nxt = ctl.target;
      JMP_WAIT_IN:  if (!st.in_valid) pc_nxt = pc_r;
      JMP_LOOP:     if (!st.cnt_last) pc_nxt = ctl.target;
      JMP_DISPATCH: pc_nxt = dispatch(st.cmd);
      JMP_NO_FREE:  if (!st.free_found) pc_nxt = ctl.target;
      JMP_NO_A:     if (!st.found_a) pc_nxt = ctl.target;
      JMP_NO_AB:    if (!(st.found_a && st.found_b)) pc_nxt = ctl.target;
      JMP_BIT_SET:  if (st.edge_bit) pc_nxt = ctl.target;
      JMP_BIT_CLR:  if (!st.edge_bit) pc_nxt = ctl.target;
      JMP_WAIT_OUT: pc_nxt = st.out_free ? ctl.target : pc_r;
      default:      pc_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire
